// ===== sv/cla_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cla_pkg - shared types and constants for the cursor luma overlay
// Register layout, request/queue item types and the divide-by-255 helper.
// ============================================================================
package cla_pkg;

   // parameter defaults
   localparam int MAX_CURSOR_SIZE_DEF = 64;
   localparam int MAX_FRAME_DIM_DEF   = 4096;

   // field widths
   localparam int PIXEL_W       = 32;
   localparam int LUMA_W        = 8;
   localparam int ADDR_W        = 24;
   localparam int FRAME_DIM_W   = 13;
   localparam int CURSOR_POS_W  = 12;
   localparam int SCALE_W       = 2;
   localparam int CURSOR_SIZE_W = 7;
   localparam int DEST_X_W      = 13;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 13;
   localparam int PROD_W        = CURSOR_POS_W + FRAME_DIM_W;
   localparam int WIDE_W        = 2 * LUMA_W;

   // register reset values
   localparam int FRAME_WIDTH_RST   = 640;
   localparam int FRAME_HEIGHT_RST  = 480;
   localparam int CURSOR_SIZE_RST   = 32;

   // BT.601 luma, 8-bit fixed point
   localparam int COEF_R      = 66;
   localparam int COEF_G      = 129;
   localparam int COEF_B      = 25;
   localparam int LUMA_OFFSET = 16;
   localparam int ALPHA_MAX   = 255;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_CURSOR_X      = 3'd2,
      CSR_CURSOR_Y      = 3'd3,
      CSR_SCALE_SHIFT   = 3'd4,
      CSR_CURSOR_WIDTH  = 3'd5,
      CSR_CURSOR_HEIGHT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [FRAME_DIM_W-1:0]   frame_width;
      logic [FRAME_DIM_W-1:0]   frame_height;
      logic [CURSOR_POS_W-1:0]  cursor_x;
      logic [CURSOR_POS_W-1:0]  cursor_y;
      logic [SCALE_W-1:0]       scale_shift;
      logic [CURSOR_SIZE_W-1:0] cursor_width;
      logic [CURSOR_SIZE_W-1:0] cursor_height;
   } cla_cfg_type;

   typedef struct packed {
      logic                    write_enable;
      logic                    last_pixel;
      logic [DEST_X_W-1:0]     dest_x;
      logic [CURSOR_POS_W-1:0] dest_y;
      logic [FRAME_DIM_W-1:0]  row_pitch;
      logic [LUMA_W-1:0]       alpha;
      logic [LUMA_W-1:0]       red;
      logic [LUMA_W-1:0]       green;
      logic [LUMA_W-1:0]       blue;
      logic [LUMA_W-1:0]       background;
   } cla_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cla_qstat_type;

   // exact floor(x/255) for x <= 255*255
   function automatic logic [LUMA_W-1:0] div255(input logic [WIDE_W-1:0] x);
      logic [WIDE_W:0] t;
      t = {1'b0, x} + (WIDE_W+1)'(x[WIDE_W-1:LUMA_W]) + (WIDE_W+1)'(1);
      return t[WIDE_W-1:LUMA_W];
   endfunction

endpackage

// ===== sv/cla_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cla_front - request intake and classification
// Walks the scaled cursor with column/row counters, resolves destination and
// bounds, and pushes one classified item per accepted request.
// ============================================================================
module cla_front #(
   parameter int MAX_CURSOR_SIZE = cla_pkg::MAX_CURSOR_SIZE_DEF,
   parameter int MAX_FRAME_DIM   = cla_pkg::MAX_FRAME_DIM_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cla_pkg::cla_cfg_type          cfg,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cla_pkg::PIXEL_W-1:0]   req_cursor_pixel,
   input  logic [cla_pkg::LUMA_W-1:0]    req_background_luma,
   input  cla_pkg::cla_qstat_type        qstat,
   output logic                          push,
   output cla_pkg::cla_item_type         item
);
   import cla_pkg::*;

   localparam int CNT_W  = $clog2(MAX_CURSOR_SIZE);
   localparam int SIZE_W = CNT_W + 1;

   logic [CNT_W-1:0]        col_ff, col_in;
   logic [CNT_W-1:0]        row_ff, row_in;
   logic [SIZE_W-1:0]       cw_cap, ch_cap, cw, ch;
   logic                    col_end, row_end;
   logic [CURSOR_POS_W-1:0] cx, cy;
   logic [FRAME_DIM_W-1:0]  fw, fh;
   logic [DEST_X_W-1:0]     dx;
   logic [CURSOR_POS_W-1:0] dy;
   logic                    row_ok, in_frame;

   always_comb begin
      if (int'(cfg.cursor_width) > MAX_CURSOR_SIZE) begin
         cw_cap = SIZE_W'(MAX_CURSOR_SIZE);
      end else begin
         cw_cap = SIZE_W'(cfg.cursor_width);
      end
      if (int'(cfg.cursor_height) > MAX_CURSOR_SIZE) begin
         ch_cap = SIZE_W'(MAX_CURSOR_SIZE);
      end else begin
         ch_cap = SIZE_W'(cfg.cursor_height);
      end
      cw = cw_cap >> cfg.scale_shift;
      ch = ch_cap >> cfg.scale_shift;
      if (cw == '0) begin
         cw = SIZE_W'(1);
      end
      if (ch == '0) begin
         ch = SIZE_W'(1);
      end

      if (int'(cfg.frame_width) > MAX_FRAME_DIM) begin
         fw = FRAME_DIM_W'(MAX_FRAME_DIM);
      end else begin
         fw = cfg.frame_width;
      end
      if (int'(cfg.frame_height) > MAX_FRAME_DIM) begin
         fh = FRAME_DIM_W'(MAX_FRAME_DIM);
      end else begin
         fh = cfg.frame_height;
      end
   end

   assign cx      = cfg.cursor_x >> cfg.scale_shift;
   assign cy      = cfg.cursor_y >> cfg.scale_shift;
   assign col_end = (SIZE_W'(col_ff) + SIZE_W'(1)) >= cw;
   assign row_end = (SIZE_W'(row_ff) + SIZE_W'(1)) >= ch;
   assign dx      = DEST_X_W'(cx) + DEST_X_W'(col_ff);
   assign row_ok  = CURSOR_POS_W'(row_ff) <= cy;
   assign dy      = cy - CURSOR_POS_W'(row_ff);
   assign in_frame = (FRAME_DIM_W'(dy) < fh) && (dx < fw);

   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   always_comb begin
      item.write_enable = (req_cursor_pixel[31:24] != '0) && row_ok && in_frame;
      item.last_pixel   = col_end && row_end;
      item.dest_x       = dx;
      item.dest_y       = dy;
      item.row_pitch    = fw;
      item.alpha        = req_cursor_pixel[31:24];
      item.red          = req_cursor_pixel[23:16];
      item.green        = req_cursor_pixel[15:8];
      item.blue         = req_cursor_pixel[7:0];
      item.background   = req_background_luma;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // the last pixel of the cursor always brings both counters home
   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      push && item.last_pixel |=> col_ff == '0 && row_ff == '0)
      else $error("counters did not wrap after last pixel");

endmodule

// ===== sv/cla_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cla_queue - short request queue between front and back
// Four-entry register queue; head entry is visible while not empty.
// ============================================================================
module cla_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cla_pkg::cla_item_type  push_item,
   input  logic                   pop,
   output cla_pkg::cla_item_type  head_item,
   output cla_pkg::cla_qstat_type qstat
);
   import cla_pkg::*;

   cla_item_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign qstat.full  = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign qstat.empty = count_ff == '0;
   assign head_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

// ===== sv/cla_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cla_back - luma, blend and address pipeline
// Stage 1: row*pitch product and weighted RGB sum. Stage 2: luma, blend
// products and address. Output register: divide by 255 and write gating.
// ============================================================================
module cla_back (
   input  logic                          clock,
   input  logic                          reset,
   input  cla_pkg::cla_item_type         head_item,
   input  cla_pkg::cla_qstat_type        qstat,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_write_enable,
   output logic [cla_pkg::ADDR_W-1:0]    rsp_dest_address,
   output logic [cla_pkg::LUMA_W-1:0]    rsp_new_luma,
   output logic                          rsp_last_pixel
);
   import cla_pkg::*;

   // stage 1
   logic                  s1_valid_ff;
   logic                  s1_we_ff, s1_last_ff;
   logic [PROD_W-1:0]     s1_prod_ff;
   logic [DEST_X_W-1:0]   s1_dx_ff;
   logic [WIDE_W-1:0]     s1_ysum_ff;
   logic [LUMA_W-1:0]     s1_alpha_ff, s1_bg_ff;
   // stage 2
   logic                  s2_valid_ff;
   logic                  s2_we_ff, s2_last_ff;
   logic [ADDR_W-1:0]     s2_addr_ff;
   logic [WIDE_W-1:0]     s2_bg_prod_ff, s2_y_prod_ff;
   // output register
   logic                  out_valid_ff;
   logic                  out_we_ff, out_last_ff;
   logic [ADDR_W-1:0]     out_addr_ff;
   logic [LUMA_W-1:0]     out_luma_ff;

   logic                  out_ready, s2_ready, s1_ready;
   logic [PROD_W-1:0]     prod_in;
   logic [WIDE_W-1:0]     ysum_in;
   logic [LUMA_W-1:0]     y_luma;
   logic [PROD_W-1:0]     addr_sum;
   logic [LUMA_W-1:0]     luma_in;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign pop       = !qstat.empty && s1_ready;

   assign prod_in = PROD_W'(head_item.dest_y) * PROD_W'(head_item.row_pitch);
   assign ysum_in = WIDE_W'(COEF_R) * WIDE_W'(head_item.red)
                  + WIDE_W'(COEF_G) * WIDE_W'(head_item.green)
                  + WIDE_W'(COEF_B) * WIDE_W'(head_item.blue);

   assign y_luma   = s1_ysum_ff[WIDE_W-1:LUMA_W] + LUMA_W'(LUMA_OFFSET);
   assign addr_sum = s1_prod_ff + PROD_W'(s1_dx_ff);
   assign luma_in  = div255(s2_bg_prod_ff) + div255(s2_y_prod_ff);

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_we_ff    <= head_item.write_enable;
         s1_last_ff  <= head_item.last_pixel;
         s1_prod_ff  <= prod_in;
         s1_dx_ff    <= head_item.dest_x;
         s1_ysum_ff  <= ysum_in;
         s1_alpha_ff <= head_item.alpha;
         s1_bg_ff    <= head_item.background;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_we_ff      <= s1_we_ff;
         s2_last_ff    <= s1_last_ff;
         s2_addr_ff    <= addr_sum[ADDR_W-1:0];
         s2_bg_prod_ff <= WIDE_W'(s1_bg_ff) * WIDE_W'(LUMA_W'(ALPHA_MAX) - s1_alpha_ff);
         s2_y_prod_ff  <= WIDE_W'(y_luma) * WIDE_W'(s1_alpha_ff);
      end
      if (s2_valid_ff && out_ready) begin
         out_we_ff   <= s2_we_ff;
         out_last_ff <= s2_last_ff;
         out_addr_ff <= s2_we_ff ? s2_addr_ff : '0;
         out_luma_ff <= s2_we_ff ? luma_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= pop;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_write_enable = out_we_ff;
   assign rsp_dest_address = out_addr_ff;
   assign rsp_new_luma     = out_luma_ff;
   assign rsp_last_pixel   = out_last_ff;

   a_suppressed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_dest_address == '0 && rsp_new_luma == '0)
      else $error("suppressed write carries nonzero payload");

   a_pop_fills_s1: assert property (@(posedge clock) disable iff (reset)
      pop |=> s1_valid_ff)
      else $error("popped request lost before stage 1");

endmodule

// ===== sv/cursor_luma_alpha_overlay.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cursor_luma_alpha_overlay - hardware cursor alpha blend into a luma plane
// Cursor ARGB pixels in raster order are converted to BT.601 luma, blended
// over the background luma and emitted as luma-plane writes.
// ============================================================================
//
//   channel  direction  handshake             payload
//   -------  ---------  --------------------  ----------------------------------
//   req      in         req_valid/req_stall   cursor_pixel, background_luma
//   rsp      out        rsp_valid/rsp_stall   write_enable, dest_address,
//                                             new_luma, last_pixel
//   csr      in         csr_write_enable      csr_index, csr_write_data
//
// One request per cycle sustained while rsp_stall is low. An accepted request
// passes the queue, product stage, blend stage and output reg before its response.
// The four-entry request queue decouples intake from the blend pipeline, so
// req_stall rises only once rsp_stall has backed the pipeline and queue up.
// Reset (synchronous, active high) empties the queue and pipeline, clears
// the cursor column/row counters and loads register defaults.
// Registers must only be written while no request is in flight; the block does not enforce it.
//
module cursor_luma_alpha_overlay #(
   parameter int MAX_CURSOR_SIZE = cla_pkg::MAX_CURSOR_SIZE_DEF,
   parameter int MAX_FRAME_DIM   = cla_pkg::MAX_FRAME_DIM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_write_enable,
   input  logic [cla_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cla_pkg::CSR_DATA_W-1:0]    csr_write_data,
   // requests
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cla_pkg::PIXEL_W-1:0]       req_cursor_pixel,
   input  logic [cla_pkg::LUMA_W-1:0]        req_background_luma,
   // responses
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_write_enable,
   output logic [cla_pkg::ADDR_W-1:0]        rsp_dest_address,
   output logic [cla_pkg::LUMA_W-1:0]        rsp_new_luma,
   output logic                              rsp_last_pixel
);
   import cla_pkg::*;

   cla_cfg_type   cfg_ff, cfg_in;
   cla_qstat_type qstat;
   cla_item_type  push_item, head_item;
   logic          push, pop;

   // register file: a write to an unused index is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:   cfg_in.frame_width   = csr_write_data[FRAME_DIM_W-1:0];
            CSR_FRAME_HEIGHT:  cfg_in.frame_height  = csr_write_data[FRAME_DIM_W-1:0];
            CSR_CURSOR_X:      cfg_in.cursor_x      = csr_write_data[CURSOR_POS_W-1:0];
            CSR_CURSOR_Y:      cfg_in.cursor_y      = csr_write_data[CURSOR_POS_W-1:0];
            CSR_SCALE_SHIFT:   cfg_in.scale_shift   = csr_write_data[SCALE_W-1:0];
            CSR_CURSOR_WIDTH:  cfg_in.cursor_width  = csr_write_data[CURSOR_SIZE_W-1:0];
            CSR_CURSOR_HEIGHT: cfg_in.cursor_height = csr_write_data[CURSOR_SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= FRAME_DIM_W'(FRAME_WIDTH_RST);
         cfg_ff.frame_height  <= FRAME_DIM_W'(FRAME_HEIGHT_RST);
         cfg_ff.cursor_x      <= '0;
         cfg_ff.cursor_y      <= '0;
         cfg_ff.scale_shift   <= '0;
         cfg_ff.cursor_width  <= CURSOR_SIZE_W'(CURSOR_SIZE_RST);
         cfg_ff.cursor_height <= CURSOR_SIZE_W'(CURSOR_SIZE_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: counters, destination and bounds, write qualification
   cla_front #(
      .MAX_CURSOR_SIZE (MAX_CURSOR_SIZE),
      .MAX_FRAME_DIM   (MAX_FRAME_DIM)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cursor_pixel    (req_cursor_pixel),
      .req_background_luma (req_background_luma),
      .qstat               (qstat),
      .push                (push),
      .item                (push_item)
   );

   // classified requests wait here for the blend pipeline
   cla_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   // back: luma conversion, alpha blend, address, output register
   cla_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_item        (head_item),
      .qstat            (qstat),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_enable (rsp_write_enable),
      .rsp_dest_address (rsp_dest_address),
      .rsp_new_luma     (rsp_new_luma),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

// ===== test/tb_cursor_luma_alpha_overlay.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_cursor_luma_alpha_overlay - self-checking bench for the cursor overlay
// Streams cursor ARGB pixels with background luma through the block under
// random request/response pacing. A bit-accurate luma blend predictor tracks
// the cursor counters and registers, and every response is compared field by
// field against the oldest predicted luma write.
// ============================================================================
module tb_cursor_luma_alpha_overlay;
   import cla_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int DRAIN_CYCLES = 8;     // request-to-response latency plus margin
   localparam int RANDOM_ITEMS = 1600;
   localparam int REPORT_LIMIT = 10;

   // one predicted luma-plane write
   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] dest_address;
      logic [LUMA_W-1:0] new_luma;
      logic              last_pixel;
   } luma_write_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_write_enable;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_write_data;
   logic                     req_valid;
   logic                     req_stall;
   logic [PIXEL_W-1:0]       req_cursor_pixel;
   logic [LUMA_W-1:0]        req_background_luma;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_write_enable;
   logic [ADDR_W-1:0]        rsp_dest_address;
   logic [LUMA_W-1:0]        rsp_new_luma;
   logic                     rsp_last_pixel;

   cursor_luma_alpha_overlay dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cursor_pixel    (req_cursor_pixel),
      .req_background_luma (req_background_luma),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_write_enable    (rsp_write_enable),
      .rsp_dest_address    (rsp_dest_address),
      .rsp_new_luma        (rsp_new_luma),
      .rsp_last_pixel      (rsp_last_pixel)
   );

   // --- register mirror and cursor walk state -------------------------------
   logic [FRAME_DIM_W-1:0]   fw_reg;
   logic [FRAME_DIM_W-1:0]   fh_reg;
   logic [CURSOR_POS_W-1:0]  cx_reg;
   logic [CURSOR_POS_W-1:0]  cy_reg;
   logic [SCALE_W-1:0]       scale_reg;
   logic [CURSOR_SIZE_W-1:0] cw_reg;
   logic [CURSOR_SIZE_W-1:0] ch_reg;
   int unsigned              col_cnt;
   int unsigned              row_cnt;

   luma_write_type expected_writes[$];

   // pacing: per-item idle draws, "steady" turns idling off for a stretch
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   int rsp_hold   = 0;

   // bookkeeping
   int error_count     = 0;
   int requests_sent   = 0;
   int csr_writes      = 0;
   int luma_writes     = 0;
   int suppressed      = 0;
   int cursor_passes   = 0;
   int random_phases   = 0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop, several times the slowest legal run.
   initial begin
      #4_000_000;
      $display("Timeout: %0d luma writes still outstanding", expected_writes.size());
      $display("Some tests failed");
      $finish;
   end

   // --- luma blend predictor ------------------------------------------------
   // Cursor size after the MAX cap and the downscale; never below one pixel.
   function automatic int unsigned reduced_dim(input logic [CURSOR_SIZE_W-1:0] size);
      int unsigned s;
      s = 32'(size);
      s = (s > MAX_CURSOR_SIZE_DEF) ? MAX_CURSOR_SIZE_DEF : s;
      s = s >> scale_reg;
      return (s == 0) ? 1 : s;
   endfunction

   // Predicts the write for one pixel and advances the column/row walk.
   function automatic luma_write_type blend_cursor_pixel(input logic [PIXEL_W-1:0] pixel,
                                                          input logic [LUMA_W-1:0] bg);
      int unsigned    alpha, red, green, blue, back;
      int unsigned    ox, oy, cw, ch, fw, fh, dx, dy, luma_y, mix, addr;
      bit             col_end, row_end;
      luma_write_type w;
      alpha   = 32'(pixel[31:24]);
      red     = 32'(pixel[23:16]);
      green   = 32'(pixel[15:8]);
      blue    = 32'(pixel[7:0]);
      back    = 32'(bg);
      ox      = 32'(cx_reg) >> scale_reg;
      oy      = 32'(cy_reg) >> scale_reg;
      cw      = reduced_dim(cw_reg);
      ch      = reduced_dim(ch_reg);
      fw      = 32'(fw_reg);
      fh      = 32'(fh_reg);
      fw      = (fw > MAX_FRAME_DIM_DEF) ? MAX_FRAME_DIM_DEF : fw;
      fh      = (fh > MAX_FRAME_DIM_DEF) ? MAX_FRAME_DIM_DEF : fh;
      dx      = ox + col_cnt;
      col_end = (col_cnt + 1 >= cw);
      row_end = (row_cnt + 1 >= ch);
      w       = '0;
      // cursor rows go upward from the origin; rows above the top are dropped
      if (alpha != 0 && row_cnt <= oy) begin
         dy = oy - row_cnt;
         if (dy < fh && dx < fw) begin
            luma_y = ((66 * red + 129 * green + 25 * blue) >> 8) + 16;
            // each weight truncates on its own
            mix    = (back * (255 - alpha)) / 255 + (luma_y * alpha) / 255;
            addr   = dy * fw + dx;
            w.write_enable = 1'b1;
            w.dest_address = addr[ADDR_W-1:0];
            w.new_luma     = mix[LUMA_W-1:0];
         end
      end
      w.last_pixel = col_end && row_end;
      if (col_end) begin
         col_cnt = 0;
         row_cnt = row_end ? 0 : row_cnt + 1;
      end else begin
         col_cnt = col_cnt + 1;
      end
      return w;
   endfunction

   // --- request side ----------------------------------------------------------
   function automatic int draw_gap(input bit steady);
      if (steady)
         return 0;
      return $urandom_range(0, 19);
   endfunction

   // Valid stays up after acceptance; the next negedge either reloads it or idles.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic [LUMA_W-1:0] bg);
      int gap;
      gap = draw_gap(req_steady);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_cursor_pixel    <= pixel;
      req_background_luma <= bg;
      do @(posedge clock); while (req_stall);
      expected_writes.push_back(blend_cursor_pixel(pixel, bg));
      requests_sent++;
   endtask

   // Hold off requests until every predicted write has come back.
   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:   fw_reg    = value[FRAME_DIM_W-1:0];
         CSR_FRAME_HEIGHT:  fh_reg    = value[FRAME_DIM_W-1:0];
         CSR_CURSOR_X:      cx_reg    = value[CURSOR_POS_W-1:0];
         CSR_CURSOR_Y:      cy_reg    = value[CURSOR_POS_W-1:0];
         CSR_SCALE_SHIFT:   scale_reg = value[SCALE_W-1:0];
         CSR_CURSOR_WIDTH:  cw_reg    = value[CURSOR_SIZE_W-1:0];
         CSR_CURSOR_HEIGHT: ch_reg    = value[CURSOR_SIZE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_writes++;
   endtask

   // Counters are not touched by register writes, only the geometry.
   task automatic load_cursor_regs(input logic [CSR_DATA_W-1:0] fw, fh, cx, cy, sh, cw, ch);
      write_csr(CSR_FRAME_WIDTH, fw);
      write_csr(CSR_FRAME_HEIGHT, fh);
      write_csr(CSR_CURSOR_X, cx);
      write_csr(CSR_CURSOR_Y, cy);
      write_csr(CSR_SCALE_SHIFT, sh);
      write_csr(CSR_CURSOR_WIDTH, cw);
      write_csr(CSR_CURSOR_HEIGHT, ch);
   endtask

   // --- response side -------------------------------------------------------
   initial begin : rsp_pacing
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      luma_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_hold = draw_gap(rsp_steady);
         if (expected_writes.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: response with nothing pending: %s",
                        $realtime,
                        $sformatf("we=%0b addr=%06h luma=%02h last=%0b",
                                  rsp_write_enable, rsp_dest_address, rsp_new_luma,
                                  rsp_last_pixel));
         end else begin
            want = expected_writes.pop_front();
            if (rsp_write_enable !== want.write_enable || rsp_dest_address !== want.dest_address
                || rsp_new_luma !== want.new_luma || rsp_last_pixel !== want.last_pixel) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: mismatch exp %s, got %s",
                           $realtime,
                           $sformatf("we=%0b addr=%06h luma=%02h last=%0b",
                                     want.write_enable, want.dest_address, want.new_luma,
                                     want.last_pixel),
                           $sformatf("we=%0b addr=%06h luma=%02h last=%0b",
                                     rsp_write_enable, rsp_dest_address, rsp_new_luma,
                                     rsp_last_pixel));
            end
            if (want.write_enable)
               luma_writes++;
            else
               suppressed++;
            if (want.last_pixel)
               cursor_passes++;
         end
      end
   end

   // --- tests ---------------------------------------------------------------
   // Reset geometry (640x480 frame, 32x32 cursor at the origin): alpha zero,
   // alpha full, alpha one, mid alpha and alpha 254 against black, white and mid-grey background.
   task automatic test_blend_extremes();
      send_pixel(32'h00FF_FFFF, 8'hFF);
      send_pixel(32'hFFFF_FFFF, 8'h00);
      send_pixel(32'hFF00_0000, 8'hFF);
      send_pixel(32'h01FF_FFFF, 8'hFF);
      send_pixel(32'h8012_3456, 8'h80);
      send_pixel(32'hFE00_0000, 8'hFF);
   endtask

   // Shrink the cursor while the column counter sits past the new width:
   // the counter must wrap on the next pixel.
   task automatic test_size_change_midway();
      wait_for_idle();
      write_csr(CSR_CURSOR_Y, 13'd1);
      write_csr(CSR_CURSOR_WIDTH, 13'd2);
      write_csr(CSR_CURSOR_HEIGHT, 13'd2);
      repeat (5) send_pixel({8'hC0, 24'($urandom)}, 8'($urandom));
   endtask

   // 3x3 cursor straddling the right edge of a 4x2 frame, with one row
   // landing above the top of the frame.
   task automatic test_frame_bounds();
      wait_for_idle();
      load_cursor_regs(13'd4, 13'd2, 13'd3, 13'd1, 13'd0, 13'd3, 13'd3);
      repeat (9) send_pixel({8'hFF, 24'($urandom)}, 8'($urandom));
   endtask

   // Zero frame width kills every write; then oversized frame and cursor
   // registers, a zero cursor width and the largest downscale.
   task automatic test_register_extremes();
      wait_for_idle();
      write_csr(CSR_FRAME_WIDTH, 13'd0);
      repeat (2) send_pixel({8'hFF, 24'($urandom)}, 8'($urandom));
      wait_for_idle();
      load_cursor_regs(13'h1FFF, 13'h1FFF, 13'hFFF, 13'hFFF, 13'd3, 13'd0, 13'h7F);
      repeat (3) send_pixel({8'h7F, 24'($urandom)}, 8'($urandom));
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_reg(input int unsigned lo, typ_hi, hi,
                                                      input int unsigned bits);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CSR_DATA_W'(lo);
         2:       return CSR_DATA_W'(hi);
         3:       return CSR_DATA_W'((1 << bits) - 1);
         default: return CSR_DATA_W'($urandom_range(lo, typ_hi));
      endcase
   endfunction

   // Random geometry per phase, mostly small cursors so passes complete often.
   task automatic test_random_cursors();
      int unsigned    sent, count;
      logic [PIXEL_W-1:0] pixel;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_for_idle();
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         load_cursor_regs(pick_reg(1, 4096, 4096, FRAME_DIM_W),
                          pick_reg(1, 4096, 4096, FRAME_DIM_W),
                          pick_reg(0, 4095, 4095, CURSOR_POS_W),
                          pick_reg(0, 4095, 4095, CURSOR_POS_W),
                          CSR_DATA_W'($urandom_range(0, 3)),
                          pick_reg(1, 12, 64, CURSOR_SIZE_W),
                          pick_reg(1, 12, 64, CURSOR_SIZE_W));
         count = $urandom_range(30, 130);
         repeat (count) begin
            pixel = $urandom;
            case ($urandom_range(0, 7))
               0, 1:    pixel[31:24] = 8'h00;
               2:       pixel[31:24] = 8'hFF;
               default: ;
            endcase
            send_pixel(pixel, 8'($urandom));
            // occasional full drain in the middle of a cursor
            if ($urandom_range(0, 99) == 0)
               wait_for_idle();
         end
         sent += count;
         random_phases++;
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_cursor_pixel    = '0;
      req_background_luma = '0;
      csr_write_enable    = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;
      fw_reg              = FRAME_DIM_W'(FRAME_WIDTH_RST);
      fh_reg              = FRAME_DIM_W'(FRAME_HEIGHT_RST);
      cx_reg              = '0;
      cy_reg              = '0;
      scale_reg           = '0;
      cw_reg              = CURSOR_SIZE_W'(CURSOR_SIZE_RST);
      ch_reg              = CURSOR_SIZE_W'(CURSOR_SIZE_RST);
      col_cnt             = 0;
      row_cnt             = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_blend_extremes();
      test_size_change_midway();
      test_frame_bounds();
      test_register_extremes();
      test_random_cursors();
      wait_for_idle();

      $display("Covered %0d cursor pixels over %0d random geometries, %0d register writes",
               requests_sent, random_phases, csr_writes);
      $display("Luma writes %0d, suppressed %0d, completed cursor passes %0d, errors %0d",
               luma_writes, suppressed, cursor_passes, error_count);
      if (error_count == 0 && expected_writes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== cursor_luma_alpha_overlay.f =====
sv/cla_pkg.sv
sv/cla_front.sv
sv/cla_queue.sv
sv/cla_back.sv
sv/cursor_luma_alpha_overlay.sv
test/tb_cursor_luma_alpha_overlay.sv
